[src/fp7seg_pkg.sv]
// shared constants, types and segment table for the fixed-point display encoder
package fp7seg_pkg;

  localparam int ValueW               = 27;
  localparam int BcdDigits            = 9;
  localparam int BcdW                 = 4 * BcdDigits;
  localparam int FracDigits           = 5;
  localparam int DigitCountDefault    = 8;
  localparam int IntegerDigitsDefault = 3;
  localparam int InDataW              = 32;
  localparam int OutDataW             = 16;
  localparam logic [7:0] PointMask    = 8'h80;

  typedef struct packed {
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } cell_data_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h7E;
      4'd1: s = 8'h30;
      4'd2: s = 8'h6D;
      4'd3: s = 8'h79;
      4'd4: s = 8'h33;
      4'd5: s = 8'h5B;
      4'd6: s = 8'h5F;
      4'd7: s = 8'h70;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h7B;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[src/fixed_point_to_seven_segment.sv]
// top level: decimal fixed-point number to seven-segment digit register writes
// Each accepted number (units of 1e-5) produces DIGIT_COUNT writes, digit 0 first,
// one per cycle while the output is ready, and the next number is taken as the last
// write of the previous one is registered; that pace is set by the single output
// port. Conversion to decimal runs through a chain of 27 shift-and-add-3 cells, one
// input bit per cell, and a number is converted while the previous one is still being
// written out, passing through the cell registers and the serializer's hold register.
module fixed_point_to_seven_segment
  import fp7seg_pkg::*;
#(
  parameter int DIGIT_COUNT    = DigitCountDefault,
  parameter int INTEGER_DIGITS = IntegerDigitsDefault
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // scaled_value[26:0], zeros
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // digit_address[3:0], segment_byte[11:4], zeros
  output logic                m_tlast    // last_digit
);

  cell_data_t chain_data  [ValueW+1];
  logic       chain_valid [ValueW+1];
  logic       chain_ready [ValueW+1];

  assign chain_data[0].bcd = '0;
  assign chain_data[0].bin = s_tdata[ValueW-1:0];
  assign chain_valid[0]    = s_tvalid;
  assign s_tready          = chain_ready[0];

  for (genvar g = 0; g < ValueW; g++) begin : g_cell
    fp7seg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  fp7seg_serializer #(
    .DIGIT_COUNT    (DIGIT_COUNT),
    .INTEGER_DIGITS (INTEGER_DIGITS)
  ) u_serializer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[ValueW]),
    .in_ready (chain_ready[ValueW]),
    .in_bcd   (chain_data[ValueW].bcd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[src/fp7seg_cell.sv]
// one shift-and-add-3 conversion cell with its own pipeline register
module fp7seg_cell
  import fp7seg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cell_data_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cell_data_t out_data
);

  logic [BcdW-1:0] adj;

  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      if (in_data.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = in_data.bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = in_data.bcd[4*i +: 4];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data.bcd <= {adj[BcdW-2:0], in_data.bin[ValueW-1]};
      out_data.bin <= {in_data.bin[ValueW-2:0], 1'b0};
    end
  end

endmodule

[src/fp7seg_serializer.sv]
// walks the digits of one converted number, one display write per cycle unless stalled
module fp7seg_serializer
  import fp7seg_pkg::*;
#(
  parameter int DIGIT_COUNT    = DigitCountDefault,
  parameter int INTEGER_DIGITS = IntegerDigitsDefault
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BcdW-1:0]     in_bcd,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,  // digit_address[3:0], segment_byte[11:4], zeros
  output logic                m_tlast
);

  localparam int PosW     = $clog2(DIGIT_COUNT);
  localparam int PlaceTop = FracDigits + INTEGER_DIGITS - 1;

  logic [BcdW-1:0] bcd;
  logic            hold_valid;
  logic [PosW-1:0] pos;
  logic            blanking;
  logic            blanking_next;
  logic            advance;
  logic            last;
  logic [3:0]      digit;
  logic [7:0]      seg;
  logic [3:0]      addr;
  logic [7:0]      seg_out;
  logic            last_out;

  assign advance  = hold_valid && (!m_tvalid || m_tready);
  assign last     = (pos == PosW'(DIGIT_COUNT - 1));
  assign in_ready = !hold_valid || (advance && last);

  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (pos == PosW'(i) && PlaceTop - i >= 0) begin
        digit = bcd[4*(PlaceTop-i) +: 4];
      end
    end
  end

  always_comb begin
    seg           = seg_of(digit);
    blanking_next = blanking;
    if (int'(pos) < INTEGER_DIGITS) begin
      if (int'(pos) == INTEGER_DIGITS - 1) begin
        seg = seg_of(digit) | PointMask;
      end else if (digit != 4'd0 || !blanking) begin
        blanking_next = 1'b0;
      end else begin
        seg = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      pos        <= '0;
      blanking   <= 1'b1;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= hold_valid;
      end
      if (advance) begin
        pos      <= last ? '0 : pos + PosW'(1);
        blanking <= blanking_next;
      end
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
        pos        <= '0;
        blanking   <= 1'b1;
      end else if (advance && last) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bcd <= in_bcd;
    end
    if (advance) begin
      addr     <= 4'(pos) + 4'd1;
      seg_out  <= seg;
      last_out <= last;
    end
  end

  assign m_tdata = {{(OutDataW-12){1'b0}}, seg_out, addr};
  assign m_tlast = last_out;

endmodule
